/* rtl/idm_pkg.sv */
// Shared constants, types and helpers for the int4 dequantising matrix-vector block.
`timescale 1ns / 1ps

package idm_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 256;
  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = 12;

  localparam int NIB_W   = 4;
  localparam int PAIRS   = MAX_COLS / 2;
  localparam int PAIR_W  = $clog2(PAIRS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int CFG_W   = 9;
  localparam int LANE_W  = VALUE_BITS + NIB_W;
  localparam int SUM_W   = 28;
  localparam int PROD_W  = SUM_W + VALUE_BITS;
  localparam int RES_W   = 32;

  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(32);

  localparam logic CFG_ACTIVE_ROWS = 1'b0;
  localparam logic CFG_ACTIVE_COLS = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD_VEC   = 2'd0,
    ACT_LOAD_SCALE = 2'd1,
    ACT_WEIGHT     = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_MERGE,
    ST_SCALE,
    ST_OUT
  } state_t;

  // Control from the sequencer to the merge stage
  typedef struct packed {
    logic             clear;
    logic             add;
    logic             close_row;
    logic             scale;
    logic             emit;
    logic [ROW_W-1:0] row;
    logic             last;
  } merge_ctl_t;

  function automatic logic signed [NIB_W-1:0] nib_signed(input logic [NIB_W-1:0] n);
    nib_signed = $signed(n);
  endfunction

endpackage

/* rtl/idm_lane.sv */
// One multiply lane: signed 4-bit weight times a Q3.12 vector element, registered.
`timescale 1ns / 1ps

module idm_lane
  import idm_pkg::*;
(
  input  logic                         clk,
  input  logic                         en,
  input  logic [NIB_W-1:0]             nibble,
  input  logic signed [VALUE_BITS-1:0] elem,
  output logic signed [LANE_W-1:0]     prod
);

  logic signed [LANE_W-1:0] prod_r;
  logic signed [LANE_W-1:0] prod_nxt;

  assign prod_nxt = LANE_W'(nib_signed(nibble)) * LANE_W'(elem);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

/* rtl/idm_merge.sv */
// Merge stage: adds the lane products into the row sum, scales a finished row, holds the result.
`timescale 1ns / 1ps

module idm_merge
  import idm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  merge_ctl_t                   ctl,
  input  logic signed [LANE_W-1:0]     prod_even,
  input  logic signed [LANE_W-1:0]     prod_odd,
  input  logic signed [VALUE_BITS-1:0] scale,
  output logic                         out_free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ROW_W-1:0]             out_row_number,
  output logic signed [RES_W-1:0]      out_row_result,
  output logic                         out_last
);

  logic signed [SUM_W-1:0]  row_sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  fin_r;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [PROD_W-1:0] mul_nxt;
  logic                     valid_r;
  logic [ROW_W-1:0]         row_r;
  logic signed [RES_W-1:0]  res_r;
  logic                     last_r;

  assign sum_nxt = row_sum_r + SUM_W'(prod_even) + SUM_W'(prod_odd);
  assign mul_nxt = fin_r * scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_sum_r <= '0;
    end else if (ctl.clear) begin
      row_sum_r <= '0;
    end else if (ctl.add) begin
      row_sum_r <= ctl.close_row ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add && ctl.close_row) begin
      fin_r <= sum_nxt;
    end
    if (ctl.scale) begin
      mul_r <= mul_nxt;
    end
  end

  // Output register: floor shift of the scaled sum, low word kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      row_r  <= ctl.row;
      res_r  <= mul_r[FRAC_BITS +: RES_W];
      last_r <= ctl.last;
    end
  end

  assign out_free       = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_row_number = row_r;
  assign out_row_result = res_r;
  assign out_last       = last_r;

endmodule

/* rtl/int4_dequant_matrix_vector.sv */
// Top level: item sequencer, vector and scale stores, two multiply lanes and the merge stage.
`timescale 1ns / 1ps
// int4_dequant_matrix_vector
// Input channel (in_valid/in_ready) takes one item: a vector element load, a row
// scale load or a packed weight byte (two signed int4 weights, low nibble first).
// Loads write the store and restart the matrix at row 0, column 0. Weight bytes
// arrive row-major; after the last byte of a row the scaled sum leaves on the
// output channel (out_valid/out_ready) with its row number and a last flag.
// Configuration (cfg_wr_en/cfg_index/cfg_wr_data) sets rows and columns in use.
// Sequence: a load writes its store and the block stays idle. A weight byte goes
// through a store read, a multiply in the two lanes and the merge stage, which adds
// both products into the row sum. A row-closing byte goes on through the 28x16 scale
// multiply and the output register load before the next item is taken. One item is
// in flight at a time; the store read port and the shared row sum set that limit.
// The output register lets the next item be taken while a result waits. If a
// row closes while the previous result is still stalled, the block holds in the
// output step until the receiver takes it, and in_ready stays low meanwhile.
// Reset (rst_n, synchronous) clears counters, row sum, output valid and restores
// 16 rows by 32 columns. Store contents are undefined until written.

module int4_dequant_matrix_vector
  import idm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_action,
  input  logic [7:0]                   in_slot_index,
  input  logic signed [VALUE_BITS-1:0] in_load_value,
  input  logic [7:0]                   in_weight_pair,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_row_number,
  output logic signed [RES_W-1:0]      out_row_result,
  output logic                         out_last,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wr_data
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  active_rows_r;
  logic [CFG_W-1:0]  active_cols_r;
  logic [PAIR_W-1:0] pair_cnt_r;
  logic [ROW_W-1:0]  row_cnt_r;

  logic [7:0]        wp_r;
  logic              row_end_r;
  logic              last_r;
  logic [ROW_W-1:0]  row_num_r;

  logic signed [VALUE_BITS-1:0] vec_even_mem [PAIRS];
  logic signed [VALUE_BITS-1:0] vec_odd_mem  [PAIRS];
  logic signed [VALUE_BITS-1:0] scale_mem    [MAX_ROWS];
  logic signed [VALUE_BITS-1:0] even_rd_r;
  logic signed [VALUE_BITS-1:0] odd_rd_r;
  logic signed [VALUE_BITS-1:0] scale_rd_r;

  logic [CFG_W-1:0]  rows_use;
  logic [CFG_W-1:0]  cols_even;
  logic [CFG_W-1:0]  cols_use;
  logic [PAIR_W:0]   pairs_use;
  logic              row_end;
  logic              row_last;

  logic              accept;
  logic              acc_vec;
  logic              acc_scale;
  logic              acc_weight;
  logic              out_free;
  logic              lane_en;
  merge_ctl_t        ctl;

  logic signed [LANE_W-1:0] prod_even;
  logic signed [LANE_W-1:0] prod_odd;

  // Clamp the configured shape
  always_comb begin
    if (active_rows_r == '0) begin
      rows_use = CFG_W'(1);
    end else if (active_rows_r > CFG_W'(MAX_ROWS)) begin
      rows_use = CFG_W'(MAX_ROWS);
    end else begin
      rows_use = active_rows_r;
    end
    cols_even = {active_cols_r[CFG_W-1:1], 1'b0};
    if (cols_even > CFG_W'(MAX_COLS)) begin
      cols_use = CFG_W'(MAX_COLS);
    end else if (cols_even < CFG_W'(2)) begin
      cols_use = CFG_W'(2);
    end else begin
      cols_use = cols_even;
    end
    pairs_use = cols_use[PAIR_W+1:1];
  end

  assign row_end  = ({1'b0, pair_cnt_r} + (PAIR_W+1)'(1)) >= pairs_use;
  assign row_last = ({1'b0, row_cnt_r} + CFG_W'(1)) >= rows_use;

  assign accept     = in_valid && in_ready;
  assign acc_vec    = accept && (action_t'(in_action) == ACT_LOAD_VEC);
  assign acc_scale  = accept && (action_t'(in_action) == ACT_LOAD_SCALE);
  assign acc_weight = accept && (action_t'(in_action) == ACT_WEIGHT);

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_rows_r <= ROWS_RESET;
      active_cols_r <= COLS_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_ACTIVE_ROWS) begin
        active_rows_r <= cfg_wr_data;
      end else begin
        active_cols_r <= cfg_wr_data;
      end
    end
  end

  // Stores: vector split into even and odd banks so both columns of a pair are read together
  always_ff @(posedge clk) begin
    if (acc_vec) begin
      if (in_slot_index[0]) begin
        vec_odd_mem[in_slot_index[PAIR_W:1]] <= in_load_value;
      end else begin
        vec_even_mem[in_slot_index[PAIR_W:1]] <= in_load_value;
      end
    end
    if (acc_scale) begin
      scale_mem[in_slot_index[ROW_W-1:0]] <= in_load_value;
    end
    if (acc_weight) begin
      even_rd_r  <= vec_even_mem[pair_cnt_r];
      odd_rd_r   <= vec_odd_mem[pair_cnt_r];
      scale_rd_r <= scale_mem[row_cnt_r];
    end
  end

  // Position counters move when the item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_cnt_r <= '0;
      row_cnt_r  <= '0;
    end else if (acc_vec || acc_scale) begin
      pair_cnt_r <= '0;
      row_cnt_r  <= '0;
    end else if (acc_weight) begin
      if (row_end) begin
        pair_cnt_r <= '0;
        row_cnt_r  <= row_last ? '0 : row_cnt_r + ROW_W'(1);
      end else begin
        pair_cnt_r <= pair_cnt_r + PAIR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_weight) begin
      wp_r      <= in_weight_pair;
      row_end_r <= row_end;
      last_r    <= row_last;
      row_num_r <= row_cnt_r;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (acc_weight) state_nxt = ST_LANE;
      ST_LANE:  state_nxt = ST_MERGE;
      ST_MERGE: state_nxt = row_end_r ? ST_SCALE : ST_IDLE;
      ST_SCALE: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    lane_en       = 1'b0;
    ctl           = '0;
    ctl.clear     = acc_vec || acc_scale;
    ctl.close_row = row_end_r;
    ctl.row       = row_num_r;
    ctl.last      = last_r;
    case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_LANE:  lane_en   = 1'b1;
      ST_MERGE: ctl.add   = 1'b1;
      ST_SCALE: ctl.scale = 1'b1;
      ST_OUT:   ctl.emit  = out_free;
      default:  in_ready  = 1'b0;
    endcase
  end

  idm_lane u_lane_even (
    .clk    (clk),
    .en     (lane_en),
    .nibble (wp_r[NIB_W-1:0]),
    .elem   (even_rd_r),
    .prod   (prod_even)
  );

  idm_lane u_lane_odd (
    .clk    (clk),
    .en     (lane_en),
    .nibble (wp_r[2*NIB_W-1:NIB_W]),
    .elem   (odd_rd_r),
    .prod   (prod_odd)
  );

  idm_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .prod_even      (prod_even),
    .prod_odd       (prod_odd),
    .scale          (scale_rd_r),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_number (out_row_number),
    .out_row_result (out_row_result),
    .out_last       (out_last)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the int4 dequantising matrix-vector block.
`timescale 1ns / 1ps

module tb
  import idm_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [7:0]  row;
    logic [31:0] value;
    logic        last;
  } row_out_t;

  typedef struct {
    action_t     act;
    logic [7:0]  slot;
    logic [15:0] value;
    logic [7:0]  pair;
    bit          typed;
    logic [7:0]  row;
    logic [31:0] result;
    bit          last;
  } probe_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_action   = ACT_NONE;
  logic [7:0]             in_slot_index  = '0;
  logic [VALUE_BITS-1:0]  in_load_value  = '0;
  logic [7:0]             in_weight_pair = '0;
  logic                   out_valid;
  logic                   out_ready   = 1'b1;
  logic [7:0]             out_row_number;
  logic [RES_W-1:0]       out_row_result;
  logic                   out_last;
  logic                   cfg_wr_en   = 1'b0;
  logic                   cfg_index   = CFG_ACTIVE_ROWS;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  // Mirror of the block's state
  logic signed [15:0] vec_copy [MAX_COLS];
  logic signed [15:0] scale_copy [MAX_ROWS];
  longint             acc_sum;
  int                 pair_cnt;
  int                 row_cnt;
  logic [CFG_W-1:0]   shape_rows;
  logic [CFG_W-1:0]   shape_cols;

  row_out_t rows_due [$];
  int       mismatches  = 0;
  bit       src_gaps    = 1'b0;
  bit       sink_stalls = 1'b0;

  // Directed items; typed results are read straight off the arithmetic
  probe_t probe_rows [22] = '{
    '{ACT_LOAD_VEC,   8'd0,   16'h1000, 8'h00, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_LOAD_VEC,   8'd1,   16'h1000, 8'h5A, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_LOAD_SCALE, 8'd0,   16'h1000, 8'hA5, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_LOAD_SCALE, 8'd1,   16'h8000, 8'h00, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_WEIGHT,     8'hFF,  16'hFFFF, 8'h77, 1'b1, 8'd0, 32'sd57344,    1'b0},
    '{ACT_WEIGHT,     8'h00,  16'h0000, 8'h88, 1'b1, 8'd1, 32'sd524288,   1'b1},
    '{ACT_NONE,       8'hFF,  16'h7FFF, 8'hFF, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_WEIGHT,     8'h3C,  16'h1234, 8'h10, 1'b1, 8'd0, 32'sd4096,     1'b0},
    '{ACT_WEIGHT,     8'hC3,  16'h8000, 8'h00, 1'b1, 8'd1, 32'sd0,        1'b1},
    '{ACT_WEIGHT,     8'h01,  16'h0001, 8'h7F, 1'b1, 8'd0, 32'sd24576,    1'b0},
    // reload mid-matrix: back to row 0
    '{ACT_LOAD_VEC,   8'd0,   16'h8000, 8'hFF, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_LOAD_VEC,   8'd1,   16'h7FFF, 8'h00, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_LOAD_SCALE, 8'd0,   16'h7FFF, 8'h00, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_WEIGHT,     8'h80,  16'h0000, 8'h88, 1'b1, 8'd0, 32'sd63,       1'b0},
    '{ACT_WEIGHT,     8'h7F,  16'hFFFF, 8'h77, 1'b1, 8'd1, 32'sd56,       1'b1},
    '{ACT_WEIGHT,     8'h00,  16'h8000, 8'h8F, 1'b1, 8'd0, -32'sd1834889, 1'b0},
    '{ACT_WEIGHT,     8'hFF,  16'h7FFF, 8'h00, 1'b1, 8'd1, 32'sd0,        1'b1},
    '{ACT_LOAD_SCALE, 8'hFF,  16'h0001, 8'h00, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_LOAD_VEC,   8'hFF,  16'hFFFF, 8'h00, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_WEIGHT,     8'h55,  16'h5555, 8'hA5, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_NONE,       8'h00,  16'h0000, 8'h00, 1'b0, 8'd0, 32'sd0,        1'b0},
    '{ACT_WEIGHT,     8'hAA,  16'hAAAA, 8'h5A, 1'b0, 8'd0, 32'sd0,        1'b0}
  };

  int4_dequant_matrix_vector i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_slot_index  (in_slot_index),
    .in_load_value  (in_load_value),
    .in_weight_pair (in_weight_pair),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_number (out_row_number),
    .out_row_result (out_row_result),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL int4_dequant_matrix_vector");
    $finish;
  end

  function automatic int nib_val(input logic [3:0] n);
    return n[3] ? int'(n) - 16 : int'(n);
  endfunction

  // Advances the mirrored state by one accepted item; returns 1 when a row closes
  function automatic bit dequant_step(input action_t act, input logic [7:0] slot,
                                      input logic [15:0] value, input logic [7:0] pair,
                                      output row_out_t res);
    int     col;
    int     pairs;
    int     rows;
    longint shifted;
    res = '0;
    case (act)
      ACT_LOAD_VEC, ACT_LOAD_SCALE: begin
        if (act == ACT_LOAD_VEC) vec_copy[slot] = value;
        else scale_copy[slot] = value;
        acc_sum  = 0;
        pair_cnt = 0;
        row_cnt  = 0;
      end
      ACT_WEIGHT: begin
        rows = int'(shape_rows);
        if (rows < 1) rows = 1;
        if (rows > MAX_ROWS) rows = MAX_ROWS;
        pairs = int'({shape_cols[CFG_W-1:1], 1'b0});
        if (pairs > MAX_COLS) pairs = MAX_COLS;
        if (pairs < 2) pairs = 2;
        pairs = pairs / 2;
        col = pair_cnt * 2;
        acc_sum += longint'(nib_val(pair[3:0])) * longint'(vec_copy[col])
                 + longint'(nib_val(pair[7:4])) * longint'(vec_copy[col + 1]);
        if (pair_cnt + 1 < pairs) begin
          pair_cnt++;
          return 1'b0;
        end
        shifted   = (acc_sum * longint'(scale_copy[row_cnt])) >>> FRAC_BITS;
        res.row   = row_cnt[7:0];
        res.value = shifted[31:0];
        res.last  = (row_cnt + 1 >= rows);
        acc_sum   = 0;
        pair_cnt  = 0;
        row_cnt   = res.last ? 0 : row_cnt + 1;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int pause_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_q312();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 16'h8000;
    if (pick < 20) return 16'h7FFF;
    if (pick < 25) return 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 200)
      $display("ERROR %0t %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic issue(input action_t act, input logic [7:0] slot, input logic [15:0] value,
                       input logic [7:0] pair, input bit typed = 1'b0,
                       input row_out_t preset = '0);
    int       gap;
    bit       made;
    row_out_t got;
    gap = (src_gaps && $urandom_range(0, 99) < 30) ? pause_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_slot_index  <= slot;
    in_load_value  <= value;
    in_weight_pair <= pair;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    made = dequant_step(act, slot, value, pair, got);
    if (typed) rows_due.insert(rows_due.size(), preset);
    else if (made) rows_due.insert(rows_due.size(), got);
  endtask

  // Always waits on the clock first, so in_valid is never driven twice in a step
  task automatic settle(input bit before_cfg);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_due.size() != 0) @(posedge clk);
    if (before_cfg) repeat (8) @(posedge clk);
  endtask

  task automatic program_shape(input int rows, input int cols);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_ACTIVE_ROWS;
    cfg_wr_data <= CFG_W'(rows);
    @(posedge clk);
    shape_rows   = CFG_W'(rows);
    cfg_index   <= CFG_ACTIVE_COLS;
    cfg_wr_data <= CFG_W'(cols);
    @(posedge clk);
    shape_cols = CFG_W'(cols);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input int rows, input int cols, input int count,
                           input int break_pct, input bit fresh);
    int pick;
    settle(1'b1);
    program_shape(rows, cols);
    src_gaps    = 1'($urandom_range(0, 1));
    sink_stalls = 1'($urandom_range(0, 1));
    if (fresh)
      issue(action_t'($urandom_range(0, 1)), 8'($urandom), rand_q312(), 8'($urandom));
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < break_pct / 2)
        issue(ACT_NONE, 8'($urandom), 16'($urandom), 8'($urandom));
      else if (pick < break_pct)
        issue(action_t'($urandom_range(0, 1)), 8'($urandom), rand_q312(), 8'($urandom));
      else
        issue(ACT_WEIGHT, 8'($urandom), 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 199) == 0) settle(1'b0);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    row_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rows_due.size() == 0) begin
        flag_mismatch("row result with none pending", longint'(out_row_number), -1);
      end else begin
        want = rows_due.pop_front();
        if (out_row_number !== want.row)
          flag_mismatch("row_number", longint'(out_row_number), longint'(want.row));
        if (out_row_result !== want.value)
          flag_mismatch("row_result", longint'($signed(out_row_result)),
                        longint'($signed(want.value)));
        if (out_last !== want.last)
          flag_mismatch("last", longint'(out_last), longint'(want.last));
      end
    end
  end

  initial begin
    acc_sum    = 0;
    pair_cnt   = 0;
    row_cnt    = 0;
    shape_rows = ROWS_RESET;
    shape_cols = COLS_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both stores so no unwritten entry is ever read
    for (int i = 0; i < MAX_COLS; i++)
      issue(ACT_LOAD_VEC, 8'(i), rand_q312(), 8'($urandom));
    for (int i = 0; i < MAX_ROWS; i++)
      issue(ACT_LOAD_SCALE, 8'(i), rand_q312(), 8'($urandom));

    // Full matrix at the reset shape, 16 rows of 16 items
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    repeat (256) issue(ACT_WEIGHT, 8'($urandom), 16'($urandom), 8'($urandom));

    settle(1'b1);
    program_shape(2, 2);
    foreach (probe_rows[k])
      issue(probe_rows[k].act, probe_rows[k].slot, probe_rows[k].value, probe_rows[k].pair,
            probe_rows[k].typed,
            '{probe_rows[k].row, probe_rows[k].result, probe_rows[k].last});

    run_phase(1, 2, 40, 10, 1'b1);
    run_phase(0, 0, 20, 10, 1'b0);
    run_phase(1, 1, 20, 0, 1'b1);
    run_phase(256, 2, 260, 0, 1'b1);
    run_phase(2, 256, 130, 0, 1'b1);
    run_phase(511, 511, 20, 10, 1'b0);
    run_phase(300, 257, 20, 10, 1'b0);
    run_phase(3, 3, 20, 10, 1'b0);
    repeat (2)
      run_phase($urandom_range(1, 6), $urandom_range(2, 17), 30, 12, 1'($urandom_range(0, 1)));

    settle(1'b1);
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("PASS int4_dequant_matrix_vector");
    else
      $display("FAIL int4_dequant_matrix_vector");
    $finish;
  end

endmodule

/* int4_dequant_matrix_vector.f */
rtl/idm_pkg.sv
rtl/idm_lane.sv
rtl/idm_merge.sv
rtl/int4_dequant_matrix_vector.sv
tb/tb.sv
